/* hw/rtl/erem_pkg.sv */
// Shared types, constants and decay factor tables for the event rate meter.
package erem_pkg;

  localparam int FRAC_BITS_DEF    = 24;
  localparam int ELAPSED_BITS_DEF = 16;
  localparam int MAX_ELAPSED_BITS = 24;
  localparam int ROM_IDX_W        = 5;

  localparam logic [31:0] Q31_ONE  = 32'h8000_0000;
  localparam logic [63:0] Q31_HALF = 64'h0000_0000_4000_0000;
  localparam logic [63:0] Q60_ONE  = 64'h1000_0000_0000_0000;

  localparam logic [63:0] TAU_SHORT = 64'd60;
  localparam logic [63:0] TAU_MID   = 64'd300;
  localparam logic [63:0] TAU_LONG  = 64'd900;

  // Taylor series of e^(-1/tau) in Q60, each term truncated in turn.
  localparam logic [63:0] S_T1 = Q60_ONE / (TAU_SHORT * 64'd1);
  localparam logic [63:0] S_T2 = S_T1 / (TAU_SHORT * 64'd2);
  localparam logic [63:0] S_T3 = S_T2 / (TAU_SHORT * 64'd3);
  localparam logic [63:0] S_T4 = S_T3 / (TAU_SHORT * 64'd4);
  localparam logic [63:0] S_T5 = S_T4 / (TAU_SHORT * 64'd5);
  localparam logic [63:0] S_T6 = S_T5 / (TAU_SHORT * 64'd6);
  localparam logic [63:0] S_T7 = S_T6 / (TAU_SHORT * 64'd7);
  localparam logic [63:0] S_T8 = S_T7 / (TAU_SHORT * 64'd8);
  localparam logic [63:0] S_T9 = S_T8 / (TAU_SHORT * 64'd9);

  localparam logic [63:0] M_T1 = Q60_ONE / (TAU_MID * 64'd1);
  localparam logic [63:0] M_T2 = M_T1 / (TAU_MID * 64'd2);
  localparam logic [63:0] M_T3 = M_T2 / (TAU_MID * 64'd3);
  localparam logic [63:0] M_T4 = M_T3 / (TAU_MID * 64'd4);
  localparam logic [63:0] M_T5 = M_T4 / (TAU_MID * 64'd5);
  localparam logic [63:0] M_T6 = M_T5 / (TAU_MID * 64'd6);
  localparam logic [63:0] M_T7 = M_T6 / (TAU_MID * 64'd7);
  localparam logic [63:0] M_T8 = M_T7 / (TAU_MID * 64'd8);
  localparam logic [63:0] M_T9 = M_T8 / (TAU_MID * 64'd9);

  localparam logic [63:0] L_T1 = Q60_ONE / (TAU_LONG * 64'd1);
  localparam logic [63:0] L_T2 = L_T1 / (TAU_LONG * 64'd2);
  localparam logic [63:0] L_T3 = L_T2 / (TAU_LONG * 64'd3);
  localparam logic [63:0] L_T4 = L_T3 / (TAU_LONG * 64'd4);
  localparam logic [63:0] L_T5 = L_T4 / (TAU_LONG * 64'd5);
  localparam logic [63:0] L_T6 = L_T5 / (TAU_LONG * 64'd6);
  localparam logic [63:0] L_T7 = L_T6 / (TAU_LONG * 64'd7);
  localparam logic [63:0] L_T8 = L_T7 / (TAU_LONG * 64'd8);
  localparam logic [63:0] L_T9 = L_T8 / (TAU_LONG * 64'd9);

  localparam logic [63:0] S_POS = Q60_ONE + S_T2 + S_T4 + S_T6 + S_T8;
  localparam logic [63:0] S_NEG = S_T1 + S_T3 + S_T5 + S_T7 + S_T9;
  localparam logic [63:0] M_POS = Q60_ONE + M_T2 + M_T4 + M_T6 + M_T8;
  localparam logic [63:0] M_NEG = M_T1 + M_T3 + M_T5 + M_T7 + M_T9;
  localparam logic [63:0] L_POS = Q60_ONE + L_T2 + L_T4 + L_T6 + L_T8;
  localparam logic [63:0] L_NEG = L_T1 + L_T3 + L_T5 + L_T7 + L_T9;

  localparam logic [31:0] BASE_SHORT = 32'(((S_POS - S_NEG) + 64'h1000_0000) >> 29);
  localparam logic [31:0] BASE_MID   = 32'(((M_POS - M_NEG) + 64'h1000_0000) >> 29);
  localparam logic [31:0] BASE_LONG  = 32'(((L_POS - L_NEG) + 64'h1000_0000) >> 29);

  typedef logic [MAX_ELAPSED_BITS-1:0][31:0] decay_row_t;

  // Entry b holds e^(-2^b/tau) in Q1.31, each one the rounded square of the last.
  function automatic decay_row_t build_row(input logic [31:0] base);
    decay_row_t row;
    logic [63:0] sq;
    row[0] = base;
    for (int b = 1; b < MAX_ELAPSED_BITS; b++) begin
      sq     = 64'(row[b-1]) * 64'(row[b-1]);
      row[b] = 32'((sq + Q31_HALF) >> 31);
    end
    return row;
  endfunction

  localparam decay_row_t ROM_SHORT = build_row(BASE_SHORT);
  localparam decay_row_t ROM_MID   = build_row(BASE_MID);
  localparam decay_row_t ROM_LONG  = build_row(BASE_LONG);

  typedef enum logic [1:0] {
    WIN_SHORT,
    WIN_MID,
    WIN_LONG
  } win_t;

  function automatic logic [31:0] decay_entry(input win_t win,
                                              input logic [ROM_IDX_W-1:0] idx);
    logic [31:0] val;
    case (win)
      WIN_SHORT: val = ROM_SHORT[idx];
      WIN_MID:   val = ROM_MID[idx];
      WIN_LONG:  val = ROM_LONG[idx];
      default:   val = '0;
    endcase
    return val;
  endfunction

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DECAY,
    OP_BLEND_A,
    OP_BLEND_B,
    OP_PUBLISH
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECAY,
    ST_BLEND_A,
    ST_BLEND_B,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t                  op;
    win_t                 win;
    logic [ROM_IDX_W-1:0] bit_idx;
  } cmd_t;

  typedef struct packed {
    logic seen_any;
    logic div_done;
  } status_t;

endpackage

/* hw/rtl/erem_div.sv */
// Restoring divider, one quotient bit per cycle, for the instant rate.
module erem_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 16,
  parameter int Q_W   = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numerator,
  input  logic [DEN_W-1:0] denominator,
  output logic [Q_W-1:0]   quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, num[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(NUM_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= numerator;
      den <= denominator;
      rem <= '0;
      quo <= '0;
    end else if (cnt != '0) begin
      num <= num << 1;
      quo <= {quo[NUM_W-2:0], fits};
      if (fits) begin
        rem <= DEN_W'(shifted - {1'b0, den});
      end else begin
        rem <= shifted[DEN_W-1:0];
      end
    end
  end

  assign quotient = quo[Q_W-1:0];

endmodule

/* hw/rtl/erem_dpath.sv */
// Datapath: event state, shared multiplier, decay and blend arithmetic, result register.
module erem_dpath #(
  parameter int FRAC_BITS    = erem_pkg::FRAC_BITS_DEF,
  parameter int ELAPSED_BITS = erem_pkg::ELAPSED_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  erem_pkg::cmd_t        cmd,
  output erem_pkg::status_t     status,
  input  logic [31:0]           event_time,
  output logic [FRAC_BITS:0]    rate_short,
  output logic [FRAC_BITS:0]    rate_mid,
  output logic [FRAC_BITS:0]    rate_long,
  output logic [63:0]           events_seen,
  output logic [31:0]           previous_event_time
);

  localparam int RATE_W   = FRAC_BITS + 1;
  localparam int NUM_W    = ((FRAC_BITS > ELAPSED_BITS) ? FRAC_BITS : ELAPSED_BITS) + 1;
  localparam int MB_W     = (RATE_W > 32) ? RATE_W : 32;
  localparam int PROD_W   = 32 + MB_W;
  localparam int DT_IDX_W = $clog2(ELAPSED_BITS);

  logic [RATE_W-1:0]       short_average;
  logic [RATE_W-1:0]       mid_average;
  logic [RATE_W-1:0]       long_average;
  logic [31:0]             last_time;
  logic                    seen_any;
  logic [63:0]             event_total;
  logic [ELAPSED_BITS-1:0] dt;
  logic [31:0]             decay;
  logic [PROD_W-1:0]       acc;

  logic [31:0]             diff;
  logic [ELAPSED_BITS-1:0] dt_calc;
  logic [NUM_W-1:0]        numerator;
  logic                    div_start;
  logic [RATE_W-1:0]       inst;
  logic                    div_done;
  logic [RATE_W-1:0]       rate_sel;
  logic [31:0]             mul_a;
  logic [MB_W-1:0]         mul_b;
  logic [PROD_W-1:0]       prod;
  logic [31:0]             decay_rounded;
  logic [PROD_W:0]         blend_sum;
  logic [RATE_W-1:0]       rate_new;

  // Elapsed time: a stall or a step back counts as one second, a long gap saturates.
  always_comb begin
    diff = event_time - last_time;
    if (diff == '0 || diff[31]) begin
      dt_calc = ELAPSED_BITS'(1);
    end else if (diff > 32'((1 << ELAPSED_BITS) - 1)) begin
      dt_calc = '1;
    end else begin
      dt_calc = diff[ELAPSED_BITS-1:0];
    end
  end

  // Half of dt is added first so the quotient is 1/dt rounded half up.
  assign numerator = (NUM_W'(1) << FRAC_BITS) + NUM_W'(dt_calc >> 1);
  assign div_start = (cmd.op == erem_pkg::OP_LOAD) && seen_any;

  erem_div #(
    .NUM_W (NUM_W),
    .DEN_W (ELAPSED_BITS),
    .Q_W   (RATE_W)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .numerator   (numerator),
    .denominator (dt_calc),
    .quotient    (inst),
    .done        (div_done)
  );

  always_comb begin
    case (cmd.win)
      erem_pkg::WIN_SHORT: rate_sel = short_average;
      erem_pkg::WIN_MID:   rate_sel = mid_average;
      erem_pkg::WIN_LONG:  rate_sel = long_average;
      default:             rate_sel = '0;
    endcase
  end

  always_comb begin
    case (cmd.op)
      erem_pkg::OP_DECAY: begin
        mul_a = decay;
        mul_b = MB_W'(erem_pkg::decay_entry(cmd.win, cmd.bit_idx));
      end
      erem_pkg::OP_BLEND_A: begin
        mul_a = erem_pkg::Q31_ONE - decay;
        mul_b = MB_W'(inst);
      end
      erem_pkg::OP_BLEND_B: begin
        mul_a = decay;
        mul_b = MB_W'(rate_sel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod          = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign decay_rounded = 32'((prod + PROD_W'(erem_pkg::Q31_HALF)) >> 31);
  assign blend_sum     = {1'b0, acc} + {1'b0, prod} + (PROD_W + 1)'(erem_pkg::Q31_HALF);
  assign rate_new      = RATE_W'(blend_sum >> 31);

  always_ff @(posedge clk) begin
    if (rst) begin
      short_average <= '0;
      mid_average   <= '0;
      long_average  <= '0;
      last_time     <= '0;
      seen_any      <= 1'b0;
      event_total   <= '0;
    end else begin
      case (cmd.op)
        erem_pkg::OP_LOAD: begin
          event_total <= event_total + 64'd1;
          last_time   <= event_time;
          seen_any    <= 1'b1;
        end
        erem_pkg::OP_BLEND_B: begin
          case (cmd.win)
            erem_pkg::WIN_SHORT: short_average <= rate_new;
            erem_pkg::WIN_MID:   mid_average   <= rate_new;
            erem_pkg::WIN_LONG:  long_average  <= rate_new;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      erem_pkg::OP_LOAD: begin
        dt    <= dt_calc;
        decay <= erem_pkg::Q31_ONE;
      end
      erem_pkg::OP_DECAY: begin
        if (dt[cmd.bit_idx[DT_IDX_W-1:0]]) begin
          decay <= decay_rounded;
        end
      end
      erem_pkg::OP_BLEND_A: begin
        acc <= prod;
      end
      erem_pkg::OP_BLEND_B: begin
        decay <= erem_pkg::Q31_ONE;
      end
      erem_pkg::OP_PUBLISH: begin
        rate_short          <= short_average;
        rate_mid            <= mid_average;
        rate_long           <= long_average;
        events_seen         <= event_total;
        previous_event_time <= last_time;
      end
      default: ;
    endcase
  end

  assign status.seen_any = seen_any;
  assign status.div_done = div_done;

endmodule

/* hw/rtl/erem_ctrl.sv */
// Controller: sequences the decay steps and blends of the three windows per event.
module erem_ctrl #(
  parameter int ELAPSED_BITS = erem_pkg::ELAPSED_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output erem_pkg::cmd_t    cmd,
  input  erem_pkg::status_t status
);

  erem_pkg::state_t                   state;
  erem_pkg::state_t                   state_next;
  erem_pkg::win_t                     win;
  erem_pkg::win_t                     win_next;
  logic [erem_pkg::ROM_IDX_W-1:0]     bit_idx;
  logic [erem_pkg::ROM_IDX_W-1:0]     bit_idx_next;
  logic                               out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= erem_pkg::ST_IDLE;
      win       <= erem_pkg::WIN_SHORT;
      bit_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      win       <= win_next;
      bit_idx   <= bit_idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    win_next     = win;
    bit_idx_next = bit_idx;
    in_stall     = 1'b1;
    cmd.op       = erem_pkg::OP_NONE;
    cmd.win      = win;
    cmd.bit_idx  = bit_idx;

    case (state)
      erem_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op       = erem_pkg::OP_LOAD;
          win_next     = erem_pkg::WIN_SHORT;
          bit_idx_next = '0;
          // The first event after reset only records its time and count; no window is blended.
          state_next   = status.seen_any ? erem_pkg::ST_DECAY : erem_pkg::ST_FINISH;
        end
      end
      erem_pkg::ST_DECAY: begin
        cmd.op       = erem_pkg::OP_DECAY;
        bit_idx_next = bit_idx + 1'b1;
        if (bit_idx == erem_pkg::ROM_IDX_W'(ELAPSED_BITS - 1)) begin
          state_next = erem_pkg::ST_BLEND_A;
        end
      end
      erem_pkg::ST_BLEND_A: begin
        if (status.div_done) begin
          cmd.op     = erem_pkg::OP_BLEND_A;
          state_next = erem_pkg::ST_BLEND_B;
        end
      end
      erem_pkg::ST_BLEND_B: begin
        cmd.op = erem_pkg::OP_BLEND_B;
        if (win == erem_pkg::WIN_LONG) begin
          state_next = erem_pkg::ST_FINISH;
        end else begin
          win_next     = (win == erem_pkg::WIN_SHORT) ? erem_pkg::WIN_MID : erem_pkg::WIN_LONG;
          bit_idx_next = '0;
          state_next   = erem_pkg::ST_DECAY;
        end
      end
      erem_pkg::ST_FINISH: begin
        // The result register takes a new beat once the previous one has left.
        if (!out_valid || !out_stall) begin
          cmd.op     = erem_pkg::OP_PUBLISH;
          state_next = erem_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = erem_pkg::ST_IDLE;
      end
    endcase

    out_valid_next = (out_valid && out_stall) || (cmd.op == erem_pkg::OP_PUBLISH);
  end

endmodule

/* hw/rtl/event_rate_ema_meter.sv */
// Top level of the event rate meter with 60, 300 and 900 second averages.
// An event that follows another passes through the decay steps and the two blend steps of each
// window before its result is published; the first event after reset goes straight to publish.
// The divider sets the first window's wait, then one shared multiply per dt bit and two per blend.
// A new event is accepted only after the last result is published, which out_stall can hold off.
// Reset clears the averages, the event count, the last time and the seen flag at once.
module event_rate_ema_meter #(
  parameter int FRAC_BITS    = erem_pkg::FRAC_BITS_DEF,
  parameter int ELAPSED_BITS = erem_pkg::ELAPSED_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        event_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FRAC_BITS:0] rate_short,
  output logic [FRAC_BITS:0] rate_mid,
  output logic [FRAC_BITS:0] rate_long,
  output logic [63:0]        events_seen,
  output logic [31:0]        previous_event_time
);

  erem_pkg::cmd_t    cmd;
  erem_pkg::status_t status;

  erem_ctrl #(
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  erem_dpath #(
    .FRAC_BITS    (FRAC_BITS),
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .event_time          (event_time),
    .rate_short          (rate_short),
    .rate_mid            (rate_mid),
    .rate_long           (rate_long),
    .events_seen         (events_seen),
    .previous_event_time (previous_event_time)
  );

endmodule

/* verif/event_rate_ema_meter_tb.sv */
// Self-checking testbench for the event rate meter: stamped events in, three decayed averages out.
module event_rate_ema_meter_tb;

  localparam int FB    = erem_pkg::FRAC_BITS_DEF;
  localparam int EB    = erem_pkg::ELAPSED_BITS_DEF;
  localparam int MAXB  = erem_pkg::MAX_ELAPSED_BITS;
  localparam int NWIN  = 3;
  localparam logic [63:0] ONE_Q31  = 64'h8000_0000;
  localparam logic [63:0] HALF_Q31 = 64'h4000_0000;
  localparam logic [63:0] DT_CAP   = (64'd1 << EB) - 64'd1;
  localparam int SETTLE_CYCLES = 70;
  localparam int RANDOM_PER_PHASE = 330;

  typedef struct {
    logic [FB:0]  rate_short;
    logic [FB:0]  rate_mid;
    logic [FB:0]  rate_long;
    logic [63:0]  count;
    logic [31:0]  stamp;
  } reading_t;

  // Tracks the meter state and holds the readings still owed by the block.
  class ema_book;
    logic [31:0] decay_tab [NWIN][MAXB];
    logic [FB:0] avg [NWIN];
    logic [31:0] last_time;
    bit          seen;
    logic [63:0] total;
    reading_t    due [$];
    int          errors;

    function new();
      logic [63:0] taus [NWIN];
      logic [63:0] sq;
      taus[erem_pkg::WIN_SHORT] = 64'd60;
      taus[erem_pkg::WIN_MID]   = 64'd300;
      taus[erem_pkg::WIN_LONG]  = 64'd900;
      for (int w = 0; w < NWIN; w++) begin
        decay_tab[w][0] = e_inv_tau(taus[w]);
        for (int b = 1; b < MAXB; b++) begin
          sq = 64'(decay_tab[w][b-1]) * 64'(decay_tab[w][b-1]);
          decay_tab[w][b] = 32'((sq + HALF_Q31) >> 31);
        end
        avg[w] = '0;
      end
      last_time = '0;
      seen = 1'b0;
      total = '0;
      errors = 0;
    endfunction

    // Alternating Taylor series in Q60 with each term truncated, rounded to Q1.31.
    function logic [31:0] e_inv_tau(input logic [63:0] tau);
      logic [63:0] term, pos, neg;
      term = 64'd1 << 60;
      pos = '0;
      neg = '0;
      for (int k = 0; k < 30 && term != 0; k++) begin
        if (k % 2 == 0) pos += term;
        else neg += term;
        term = term / (tau * 64'(k + 1));
      end
      return 32'(((pos - neg) + (64'd1 << 28)) >> 29);
    endfunction

    function logic [63:0] decay_of(input int w, input logic [63:0] dt);
      logic [63:0] d;
      d = ONE_Q31;
      for (int b = 0; b < EB && b < MAXB; b++)
        if (dt[b]) d = (d * 64'(decay_tab[w][b]) + HALF_Q31) >> 31;
      return d;
    endfunction

    function logic [FB:0] blend(input logic [FB:0] rate, input logic [63:0] inst,
                                input logic [63:0] d);
      logic [63:0] acc;
      acc = (ONE_Q31 - d) * inst + d * 64'(rate);
      return (FB + 1)'((acc + HALF_Q31) >> 31);
    endfunction

    function void record_event(input logic [31:0] t);
      logic [31:0] diff;
      logic [63:0] dt, inst;
      reading_t r;
      total = total + 64'd1;
      if (!seen) begin
        seen = 1'b1;
        last_time = t;
      end else begin
        diff = t - last_time;
        // Time standing still or stepping back counts as one second.
        dt = (diff == 0 || diff[31]) ? 64'd1 : 64'(diff);
        if (dt > DT_CAP) dt = DT_CAP;
        inst = ((64'd1 << FB) + dt / 64'd2) / dt;
        for (int w = 0; w < NWIN; w++) avg[w] = blend(avg[w], inst, decay_of(w, dt));
        last_time = t;
      end
      r.rate_short = avg[erem_pkg::WIN_SHORT];
      r.rate_mid   = avg[erem_pkg::WIN_MID];
      r.rate_long  = avg[erem_pkg::WIN_LONG];
      r.count      = total;
      r.stamp      = last_time;
      due.push_back(r);
    endfunction

    function void compare(input string field, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_reading(input logic [FB:0] rs, input logic [FB:0] rm,
                                input logic [FB:0] rl, input logic [63:0] cnt,
                                input logic [31:0] stamp);
      reading_t r;
      if (due.size() == 0) begin
        $display("%0t: unexpected reading, expected none actual count %h", $time, cnt);
        errors++;
      end else begin
        r = due.pop_front();
        compare("rate_short", 64'(r.rate_short), 64'(rs));
        compare("rate_mid", 64'(r.rate_mid), 64'(rm));
        compare("rate_long", 64'(r.rate_long), 64'(rl));
        compare("events_seen", r.count, cnt);
        compare("previous_event_time", 64'(r.stamp), 64'(stamp));
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] event_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [FB:0] rate_short;
  logic [FB:0] rate_mid;
  logic [FB:0] rate_long;
  logic [63:0] events_seen;
  logic [31:0] previous_event_time;

  ema_book     book = new();
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [31:0] last_stamp = '0;

  event_rate_ema_meter #(
    .FRAC_BITS(FB),
    .ELAPSED_BITS(EB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .event_time(event_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rate_short(rate_short),
    .rate_mid(rate_mid),
    .rate_long(rate_long),
    .events_seen(events_seen),
    .previous_event_time(previous_event_time)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("event_rate_ema_meter regression: fail");
    $finish;
  end

  // Output side: signals sampled at the edge hold their values from before it.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        book.check_reading(rate_short, rate_mid, rate_long, events_seen, previous_event_time);
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic send_stamp(input logic [31:0] t);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    event_time <= t;
    do @(posedge clk); while (in_stall);
    book.record_event(t);
    last_stamp = t;
  endtask

  // Holds the sender off until every owed reading has come back.
  task automatic drain_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  function automatic logic [31:0] pick_stamp();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return last_stamp + $urandom_range(1, 120);
    else if (sel < 70) return last_stamp + $urandom_range(1, 3);
    else if (sel < 80) return last_stamp + $urandom_range(200, 70000);
    else if (sel < 88) return $urandom();
    else if (sel < 94) return last_stamp;
    else return last_stamp - $urandom_range(1, 1000);
  endfunction

  task automatic random_phase(input int sender_idle, input int receiver_stall);
    send_idle_pct  = sender_idle;
    recv_stall_pct = receiver_stall;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if (i == RANDOM_PER_PHASE / 2) drain_readings();
      send_stamp(pick_stamp());
    end
  endtask

  initial begin
    logic [31:0] jumps [18];
    jumps = '{32'h10, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF,
              32'h1_0000, 32'h2, 32'h3, 32'd60, 32'd300, 32'd900, 32'h5555, 32'hAAAA,
              32'h1, 32'h1, 32'h1, 32'h1};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed beats: the first event only stores its time and count, then standstill, wrap,
    // backward steps, the half-range boundary, saturation and its edge.
    send_idle_pct  = 12;
    recv_stall_pct = 78;
    send_stamp(32'hFFFF_FFF0);
    send_stamp(32'hFFFF_FFF0);
    foreach (jumps[i]) send_stamp(last_stamp + jumps[i]);
    send_stamp(32'h5555_5555);
    send_stamp(32'hAAAA_AAAA);
    send_stamp(32'h0000_0000);
    drain_readings();

    random_phase(12, 78);
    drain_readings();
    random_phase(78, 12);
    drain_readings();
    random_phase(0, 0);

    drain_readings();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("event_rate_ema_meter regression: pass");
    end else begin
      $display("event_rate_ema_meter regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/erem_pkg.sv
hw/rtl/erem_div.sv
hw/rtl/erem_dpath.sv
hw/rtl/erem_ctrl.sv
hw/rtl/event_rate_ema_meter.sv
verif/event_rate_ema_meter_tb.sv
